>>> sv/duer_pkg.sv
// Shared types and constants for the dual ultrasonic echo ranger.
// No dependencies; imported by duer_fold, the top level and the bench.
package duer_pkg;

  localparam int CHANNELS  = 2;
  localparam int CH_W      = 1;
  localparam int TIMEOUT_W = 17;
  localparam int MM_W      = 16;
  localparam int CNT_W     = 32;
  localparam int ADDR_W    = 5;

  // 0.1715 mm/us in unsigned Q16
  localparam logic [13:0] MM_PER_US_Q16 = 14'd11239;

  localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 17'd25000;
  localparam logic [MM_W-1:0]      MIN_VALID_RST    = 16'd20;
  localparam logic [MM_W-1:0]      MAX_VALID_RST    = 16'd4000;
  localparam logic [15:0]          STALE_RST        = 16'd300;
  localparam logic [15:0]          PERIOD_RST       = 16'd60;

  typedef enum logic [2:0] {
    REG_ECHO_TIMEOUT  = 3'd0,
    REG_MIN_VALID     = 3'd1,
    REG_MAX_VALID     = 3'd2,
    REG_STALE_TIMEOUT = 3'd3,
    REG_CYCLE_PERIOD  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] echo_timeout;
    logic [MM_W-1:0]      min_mm;
    logic [MM_W-1:0]      max_mm;
  } fold_cfg_t;

  typedef struct packed {
    logic            consumed;
    logic            good;
    logic [MM_W-1:0] mm;
  } fold_res_t;

endpackage

>>> sv/duer_fold.sv
// Per-channel width-to-distance conversion and validity check.
// Depends on duer_pkg.
module duer_fold (
  input  logic [31:0]         width_i,
  input  logic                ready_i,
  input  duer_pkg::fold_cfg_t cfg_i,
  output duer_pkg::fold_res_t res_o
);
  import duer_pkg::*;

  logic [30:0]     prod;
  logic [MM_W-1:0] mm;
  logic            in_range;

  // a width that passes the timeout check fits in 17 bits
  assign prod     = {14'b0, width_i[TIMEOUT_W-1:0]} * {17'b0, MM_PER_US_Q16};
  assign mm       = {1'b0, prod[30:16]};
  assign in_range = (width_i != 32'd0) && (width_i <= {15'b0, cfg_i.echo_timeout});

  always_comb begin
    res_o.consumed = ready_i;
    res_o.mm       = mm;
    res_o.good     = ready_i && in_range && (mm != '0) &&
                     (mm >= cfg_i.min_mm) && (mm <= cfg_i.max_mm);
  end

endmodule

>>> sv/dual_ultrasonic_echo_ranger.sv
// Top level of the dual ultrasonic echo ranger: input stage, channel state,
// update logic, result register and APB-style configuration registers.
// Depends on duer_pkg and duer_fold.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  op, channel, level, time_us, now_ms
//   out      out_valid/ out_stall left/right mm+ok, any_ok, fire_ping, counters
//   cfg      psel/penable/pwrite  paddr[4:2] selects register, pwdata/prdata
//
// One transaction per clock: an item is registered in the input stage, then applied
// to the channel state; an update loads the result register along with it.
// Edge items never wait. An update waits in the input stage only while the
// result register is full and stalled, which then stalls the input.
// Reset (synchronous, rst_n low) clears the valid flags, channel state and counters and loads register defaults.
module dual_ultrasonic_echo_ranger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic                       in_channel,
  input  logic                       in_level,
  input  logic [31:0]                in_time_us,
  input  logic [31:0]                in_now_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_left_mm,
  output logic                       out_left_ok,
  output logic [15:0]                out_right_dist,
  output logic                       out_right_ok,
  output logic                       out_any_ok,
  output logic                       out_fire_ping,
  output logic [31:0]                out_left_echoes,
  output logic [31:0]                out_right_echoes,
  output logic [31:0]                out_left_misses,
  output logic [31:0]                out_right_misses,
  output logic [31:0]                out_ping_count,
  output logic [31:0]                out_reading_time_ms,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [duer_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import duer_pkg::*;

  // configuration
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [MM_W-1:0]      min_r, max_r;
  logic [15:0]          stale_r, period_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  fold_cfg_t            fcfg;

  // input stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_op_r, s1_ch_r, s1_level_r;
  logic [31:0]      s1_time_r, s1_now_r;
  logic             in_acc, s1_go, s1_upd, s1_edge;

  // channel state
  logic [31:0]      rise_r   [CHANNELS];
  logic [31:0]      rise_nxt [CHANNELS];
  logic [31:0]      width_r  [CHANNELS];
  logic [31:0]      width_nxt[CHANNELS];
  logic [CHANNELS-1:0] ready_r, ready_nxt;
  logic [MM_W-1:0]  dist_r   [CHANNELS];
  logic [MM_W-1:0]  dist_nxt [CHANNELS];
  logic [CHANNELS-1:0] dok_r, dok_nxt, dok_fold;
  logic [CNT_W-1:0] echo_r   [CHANNELS];
  logic [CNT_W-1:0] echo_nxt [CHANNELS];
  logic [CNT_W-1:0] miss_r   [CHANNELS];
  logic [CNT_W-1:0] miss_nxt [CHANNELS];
  logic [31:0]      last_rd_r, last_rd_nxt, last_rd_fold;
  logic [31:0]      last_ping_r, last_ping_nxt;
  logic [CNT_W-1:0] pings_r, pings_nxt;
  fold_res_t        fres [CHANNELS];
  logic             stale, fire;
  logic [31:0]      rd_age, ping_age;

  // result register
  logic             out_valid_r, out_valid_nxt, out_load;
  logic             fire_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  assign fcfg.echo_timeout = timeout_r;
  assign fcfg.min_mm       = min_r;
  assign fcfg.max_mm       = max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ECHO_TIMEOUT_RST;
      min_r     <= MIN_VALID_RST;
      max_r     <= MAX_VALID_RST;
      stale_r   <= STALE_RST;
      period_r  <= PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ECHO_TIMEOUT:  timeout_r <= pwdata[TIMEOUT_W-1:0];
        REG_MIN_VALID:     min_r     <= pwdata[MM_W-1:0];
        REG_MAX_VALID:     max_r     <= pwdata[MM_W-1:0];
        REG_STALE_TIMEOUT: stale_r   <= pwdata[15:0];
        REG_CYCLE_PERIOD:  period_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ECHO_TIMEOUT:  prdata = {15'b0, timeout_r};
      REG_MIN_VALID:     prdata = {16'b0, min_r};
      REG_MAX_VALID:     prdata = {16'b0, max_r};
      REG_STALE_TIMEOUT: prdata = {16'b0, stale_r};
      REG_CYCLE_PERIOD:  prdata = {16'b0, period_r};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------- input stage handshake ----------------
  assign s1_go    = s1_valid_r && (!s1_op_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign s1_upd   = s1_go && s1_op_r;
  assign s1_edge  = s1_go && !s1_op_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op;
      s1_ch_r    <= in_channel;
      s1_level_r <= in_level;
      s1_time_r  <= in_time_us;
      s1_now_r   <= in_now_ms;
    end
  end

  // ---------------- per-channel conversion ----------------
  for (genvar g = 0; g < CHANNELS; g++) begin : g_fold
    duer_fold u_fold (
      .width_i (width_r[g]),
      .ready_i (ready_r[g]),
      .cfg_i   (fcfg),
      .res_o   (fres[g])
    );
  end

  // ---------------- update logic ----------------
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      dok_fold[ch] = fres[ch].consumed ? fres[ch].good : dok_r[ch];
    end
    last_rd_fold = last_rd_r;
    if (fres[0].consumed || fres[1].consumed) begin
      last_rd_fold = s1_now_r;
    end
    rd_age   = s1_now_r - last_rd_fold;
    ping_age = s1_now_r - last_ping_r;
    stale    = rd_age > {16'b0, stale_r};
    fire     = (last_ping_r == 32'd0) || (ping_age >= {16'b0, period_r});
  end

  always_comb begin
    ready_nxt     = ready_r;
    dok_nxt       = dok_r;
    last_rd_nxt   = last_rd_r;
    last_ping_nxt = last_ping_r;
    pings_nxt     = pings_r;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      rise_nxt[ch]  = rise_r[ch];
      width_nxt[ch] = width_r[ch];
      dist_nxt[ch]  = dist_r[ch];
      echo_nxt[ch]  = echo_r[ch];
      miss_nxt[ch]  = miss_r[ch];
      if (s1_edge && (s1_ch_r == CH_W'(ch))) begin
        if (s1_level_r) begin
          rise_nxt[ch] = s1_time_r;
        end else begin
          width_nxt[ch] = s1_time_r - rise_r[ch];
          ready_nxt[ch] = 1'b1;
        end
      end
      if (s1_upd) begin
        dok_nxt[ch] = dok_fold[ch] && !stale;
        if (fres[ch].consumed) begin
          ready_nxt[ch] = 1'b0;
          echo_nxt[ch]  = echo_r[ch] + 32'd1;
          if (fres[ch].good) begin
            dist_nxt[ch] = fres[ch].mm;
          end else begin
            miss_nxt[ch] = miss_r[ch] + 32'd1;
          end
        end
      end
    end
    if (s1_upd) begin
      last_rd_nxt = last_rd_fold;
      if (fire) begin
        last_ping_nxt = s1_now_r;
        pings_nxt     = pings_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= '0;
      dok_r       <= '0;
      last_rd_r   <= '0;
      last_ping_r <= '0;
      pings_r     <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        rise_r[ch]  <= '0;
        width_r[ch] <= '0;
        dist_r[ch]  <= '0;
        echo_r[ch]  <= '0;
        miss_r[ch]  <= '0;
      end
    end else begin
      ready_r     <= ready_nxt;
      dok_r       <= dok_nxt;
      last_rd_r   <= last_rd_nxt;
      last_ping_r <= last_ping_nxt;
      pings_r     <= pings_nxt;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        rise_r[ch]  <= rise_nxt[ch];
        width_r[ch] <= width_nxt[ch];
        dist_r[ch]  <= dist_nxt[ch];
        echo_r[ch]  <= echo_nxt[ch];
        miss_r[ch]  <= miss_nxt[ch];
      end
    end
  end

  // ---------------- result register ----------------
  assign out_load      = s1_upd;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_mm         <= dist_nxt[0];
      out_left_ok         <= dok_nxt[0];
      out_right_dist      <= dist_nxt[1];
      out_right_ok        <= dok_nxt[1];
      out_any_ok          <= |dok_nxt;
      fire_r              <= fire;
      out_left_echoes     <= echo_nxt[0];
      out_right_echoes    <= echo_nxt[1];
      out_left_misses     <= miss_nxt[0];
      out_right_misses    <= miss_nxt[1];
      out_ping_count      <= pings_nxt;
      out_reading_time_ms <= last_rd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_fire_ping = fire_r;

endmodule

>>> sv/duer_checker.sv
// Port-level checker for the dual ultrasonic echo ranger, bound to the top level.
// Depends on dual_ultrasonic_echo_ranger port names only.
module duer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_left_ok,
  input logic        out_right_ok,
  input logic        out_any_ok,
  input logic [31:0] out_ping_count
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_any_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_any_ok == (out_left_ok || out_right_ok)))
    else $error("any_ok disagrees with channel ok bits");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ping_count))
    else $error("stalled result changed");

endmodule

bind dual_ultrasonic_echo_ranger duer_checker u_duer_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_left_ok    (out_left_ok),
  .out_right_ok   (out_right_ok),
  .out_any_ok     (out_any_ok),
  .out_ping_count (out_ping_count)
);

>>> verif/echo_range_checker.sv
`timescale 1ns / 100ps
// Ranging predictor and result checker for the dual ultrasonic echo ranger bench.
// Also holds the op codes shared with tb; depends on duer_pkg.
package ranger_tb_pkg;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_UPDATE = 1'b1
  } ranger_op_t;

endpackage

module echo_range_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_channel,
  input  logic                        in_level,
  input  logic [31:0]                 in_time_us,
  input  logic [31:0]                 in_now_ms,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [15:0]                 out_left_mm,
  input  logic                        out_left_ok,
  input  logic [15:0]                 out_right_dist,
  input  logic                        out_right_ok,
  input  logic                        out_any_ok,
  input  logic                        out_fire_ping,
  input  logic [31:0]                 out_left_echoes,
  input  logic [31:0]                 out_right_echoes,
  input  logic [31:0]                 out_left_misses,
  input  logic [31:0]                 out_right_misses,
  input  logic [31:0]                 out_ping_count,
  input  logic [31:0]                 out_reading_time_ms,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [duer_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          readings_pending
);
  import duer_pkg::*;
  import ranger_tb_pkg::*;

  typedef struct packed {
    logic [15:0] left_mm;
    logic        left_ok;
    logic [15:0] right_dist;
    logic        right_ok;
    logic        any_ok;
    logic        fire_ping;
    logic [31:0] left_echoes;
    logic [31:0] right_echoes;
    logic [31:0] left_misses;
    logic [31:0] right_misses;
    logic [31:0] ping_count;
    logic [31:0] reading_time_ms;
  } range_reading_t;

  // 0.1715 mm/us, Q16
  localparam logic [47:0] Q16_MM_PER_US = 48'd11239;

  logic [TIMEOUT_W-1:0] timeout_us;
  logic [15:0]          min_mm;
  logic [15:0]          max_mm;
  logic [15:0]          stale_ms;
  logic [15:0]          period_ms;

  logic [31:0] rise_us     [CHANNELS];
  logic [31:0] echo_width  [CHANNELS];
  logic        width_ready [CHANNELS];
  logic [15:0] dist_mm     [CHANNELS];
  logic        dist_ok     [CHANNELS];
  logic [31:0] echo_cnt    [CHANNELS];
  logic [31:0] miss_cnt    [CHANNELS];
  logic [31:0] last_reading_ms;
  logic [31:0] last_ping_ms;
  logic [31:0] pings;

  range_reading_t expected_readings[$];
  int errs = 0;
  int queued = 0;

  assign fail_count       = errs;
  assign readings_pending = queued;

  task automatic clear_state();
    timeout_us = 17'd25000;
    min_mm     = 16'd20;
    max_mm     = 16'd4000;
    stale_ms   = 16'd300;
    period_ms  = 16'd60;
    for (int c = 0; c < CHANNELS; c++) begin
      rise_us[c]     = '0;
      echo_width[c]  = '0;
      width_ready[c] = 1'b0;
      dist_mm[c]     = '0;
      dist_ok[c]     = 1'b0;
      echo_cnt[c]    = '0;
      miss_cnt[c]    = '0;
    end
    last_reading_ms = '0;
    last_ping_ms    = '0;
    pings           = '0;
    expected_readings.delete();
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
    case (reg_idx_t'(idx))
      REG_ECHO_TIMEOUT:  timeout_us = data[TIMEOUT_W-1:0];
      REG_MIN_VALID:     min_mm     = data[15:0];
      REG_MAX_VALID:     max_mm     = data[15:0];
      REG_STALE_TIMEOUT: stale_ms   = data[15:0];
      REG_CYCLE_PERIOD:  period_ms  = data[15:0];
      default: ;
    endcase
  endtask

  // consume a pending width on one channel
  task automatic fold_echo(input int c, input logic [31:0] now);
    logic [31:0] w;
    logic [47:0] prod;
    logic [31:0] mm;
    logic        good;
    if (!width_ready[c]) return;
    width_ready[c] = 1'b0;
    w    = echo_width[c];
    good = (w != 0) && (w <= {15'd0, timeout_us});
    prod = {16'd0, w} * Q16_MM_PER_US;
    mm   = prod[47:16];
    if (good && (mm < {16'd0, min_mm} || mm > {16'd0, max_mm} || mm == 0))
      good = 1'b0;
    echo_cnt[c] = echo_cnt[c] + 1;
    dist_ok[c]  = good;
    if (good) dist_mm[c] = mm[15:0];
    else miss_cnt[c] = miss_cnt[c] + 1;
    last_reading_ms = now;
  endtask

  task automatic predict_ranging(input ranger_op_t op, input logic ch, input logic lvl,
                                 input logic [31:0] t_us, input logic [31:0] now);
    range_reading_t r;
    logic [31:0]    age;
    logic [31:0]    ping_age;
    if (op == OP_EDGE) begin
      if (lvl) rise_us[ch] = t_us;
      else begin
        echo_width[ch]  = t_us - rise_us[ch];
        width_ready[ch] = 1'b1;
      end
      return;
    end
    fold_echo(0, now);
    fold_echo(1, now);
    age = now - last_reading_ms;
    if (age > {16'd0, stale_ms}) begin
      dist_ok[0] = 1'b0;
      dist_ok[1] = 1'b0;
    end
    ping_age    = now - last_ping_ms;
    r.fire_ping = (last_ping_ms == 0) || (ping_age >= {16'd0, period_ms});
    if (r.fire_ping) begin
      last_ping_ms = now;
      pings        = pings + 1;
    end
    r.left_mm         = dist_mm[0];
    r.left_ok         = dist_ok[0];
    r.right_dist      = dist_mm[1];
    r.right_ok        = dist_ok[1];
    r.any_ok          = dist_ok[0] | dist_ok[1];
    r.left_echoes     = echo_cnt[0];
    r.right_echoes    = echo_cnt[1];
    r.left_misses     = miss_cnt[0];
    r.right_misses    = miss_cnt[1];
    r.ping_count      = pings;
    r.reading_time_ms = last_reading_ms;
    expected_readings.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_reading();
    range_reading_t r;
    if (expected_readings.size() == 0) begin
      $error("result transaction with no expected reading");
      errs++;
      return;
    end
    r = expected_readings.pop_front();
    check_field("left_mm", 32'(r.left_mm), 32'(out_left_mm));
    check_field("left_ok", 32'(r.left_ok), 32'(out_left_ok));
    check_field("right_dist", 32'(r.right_dist), 32'(out_right_dist));
    check_field("right_ok", 32'(r.right_ok), 32'(out_right_ok));
    check_field("any_ok", 32'(r.any_ok), 32'(out_any_ok));
    check_field("fire_ping", 32'(r.fire_ping), 32'(out_fire_ping));
    check_field("left_echoes", r.left_echoes, out_left_echoes);
    check_field("right_echoes", r.right_echoes, out_right_echoes);
    check_field("left_misses", r.left_misses, out_left_misses);
    check_field("right_misses", r.right_misses, out_right_misses);
    check_field("ping_count", r.ping_count, out_ping_count);
    check_field("reading_time_ms", r.reading_time_ms, out_reading_time_ms);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_valid && !out_stall) check_reading();
      if (psel && penable && pwrite && pready) write_cfg(paddr[4:2], pwdata);
      if (in_valid && !in_stall)
        predict_ranging(ranger_op_t'(in_op), in_channel, in_level, in_time_us, in_now_ms);
    end
    queued = expected_readings.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the dual ultrasonic echo ranger: echo edges, updates,
// register phases and random stalls. Depends on duer_pkg and echo_range_checker.
module tb;
  import duer_pkg::*;
  import ranger_tb_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int MM_STEP_Q16   = 11239;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic              in_channel;
  logic              in_level;
  logic [31:0]       in_time_us;
  logic [31:0]       in_now_ms;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       out_left_mm;
  logic              out_left_ok;
  logic [15:0]       out_right_dist;
  logic              out_right_ok;
  logic              out_any_ok;
  logic              out_fire_ping;
  logic [31:0]       out_left_echoes;
  logic [31:0]       out_right_echoes;
  logic [31:0]       out_left_misses;
  logic [31:0]       out_right_misses;
  logic [31:0]       out_ping_count;
  logic [31:0]       out_reading_time_ms;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                readings_pending;

  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  logic        hold_req = 1'b0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [31:0] us_clk;
  logic [31:0] ms_clk;
  int          cfg_timeout = 25000;
  int          cfg_min = 20;
  int          cfg_max = 4000;

  dual_ultrasonic_echo_ranger dut (.*);
  echo_range_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pwrite))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[dual_ultrasonic_echo_ranger] ERROR");
    $finish;
  end

  task automatic push_item(input ranger_op_t op, input logic ch, input logic lvl,
                           input logic [31:0] t_us, input logic [31:0] now);
    if (!tx_quiet && $urandom_range(0, 6) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_op      <= op;
    in_channel <= ch;
    in_level   <= lvl;
    in_time_us <= t_us;
    in_now_ms  <= now;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic edge_item(input logic ch, input logic lvl, input logic [31:0] t_us);
    push_item(OP_EDGE, ch, lvl, t_us, $urandom);
  endtask

  task automatic update_item(input logic [31:0] now);
    push_item(OP_UPDATE, 1'($urandom), 1'($urandom), $urandom, now);
  endtask

  // wait for the block to drain, including edge transactions still in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ECHO_TIMEOUT: cfg_timeout = int'(val[TIMEOUT_W-1:0]);
      REG_MIN_VALID:    cfg_min     = int'(val[15:0]);
      REG_MAX_VALID:    cfg_max     = int'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] tmo, input logic [31:0] mn,
                            input logic [31:0] mx, input logic [31:0] stale,
                            input logic [31:0] period);
    write_reg(REG_ECHO_TIMEOUT, tmo);
    write_reg(REG_MIN_VALID, mn);
    write_reg(REG_MAX_VALID, mx);
    write_reg(REG_STALE_TIMEOUT, stale);
    write_reg(REG_CYCLE_PERIOD, period);
  endtask

  function automatic logic [31:0] pick_width();
    logic [31:0] bound;
    bound = $urandom_range(0, 1) ? cfg_max : cfg_min;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(1, cfg_timeout + 1);
      4:          return $urandom_range(0, 12);
      5:          return cfg_timeout + $urandom_range(0, 2) - 1;
      6:          return $urandom;
      default:    return ((bound << 16) / MM_STEP_Q16) + $urandom_range(0, 12) - 6;
    endcase
  endfunction

  // mostly rise/fall pairs followed by an update, some raw noise
  task automatic random_burst();
    logic [31:0] w;
    if ($urandom_range(0, 9) < 7) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if ($urandom_range(0, 4) != 0) begin
          w = pick_width();
          us_clk += $urandom_range(0, 2000);
          edge_item(c[0], 1'b1, us_clk);
          us_clk += w;
          edge_item(c[0], 1'b0, us_clk);
          if ($urandom_range(0, 9) == 0)
            edge_item(c[0], 1'b0, us_clk + $urandom_range(0, 3000));
        end
      end
      ms_clk += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 400);
      update_item(ms_clk);
    end else begin
      push_item(ranger_op_t'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                $urandom, $urandom);
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) random_burst();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_EDGE;
    in_channel = 1'b0;
    in_level   = 1'b0;
    in_time_us = '0;
    in_now_ms  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    us_clk     = $urandom;
    ms_clk     = $urandom;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: ping at time zero, wrap of the width, overwrite, limits
    update_item(32'd0);
    update_item(32'd0);
    edge_item(1'b0, 1'b0, 32'd1000);
    edge_item(1'b1, 1'b1, 32'hFFFF_FF00);
    edge_item(1'b1, 1'b0, 32'h0000_0100);
    update_item(32'd10);
    edge_item(1'b0, 1'b1, 32'hFFFF_FFFF);
    edge_item(1'b0, 1'b0, 32'hFFFF_FFFF);
    edge_item(1'b0, 1'b0, 32'd9999);
    edge_item(1'b1, 1'b1, 32'd0);
    edge_item(1'b1, 1'b0, 32'd25001);
    update_item(32'd40);
    update_item(32'd400);
    edge_item(1'b0, 1'b1, 32'd0);
    edge_item(1'b0, 1'b0, 32'd100);
    edge_item(1'b1, 1'b1, 32'd0);
    edge_item(1'b1, 1'b0, 32'd23500);
    update_item(32'hFFFF_FFFF);
    settle();

    // widest limits, zero period; upper data bits must be dropped
    set_config(32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hABCD_0000);
    edge_item(1'b0, 1'b0, 32'd5);
    edge_item(1'b1, 1'b1, 32'd0);
    edge_item(1'b1, 1'b0, 32'h0001_FFFF);
    update_item(32'd1);
    edge_item(1'b1, 1'b1, 32'h0000_0010);
    edge_item(1'b1, 1'b0, 32'h0002_0010);
    update_item(32'd1);
    run_random(110);
    settle();

    // nothing can be valid: zero timeout, min above max
    set_config(32'd0, 32'h0000_FFFF, 32'd0, 32'd0, 32'h0000_FFFF);
    run_random(110);
    settle();

    set_config(($urandom & 32'hFFFE_0000) | $urandom_range(0, 100000),
               ($urandom & 32'hFFFF_0000) | $urandom_range(0, 300),
               ($urandom & 32'hFFFF_0000) | $urandom_range(1000, 65535),
               ($urandom & 32'hFFFF_0000) | $urandom_range(0, 500),
               ($urandom & 32'hFFFF_0000) | $urandom_range(0, 200));
    run_random(110);
    settle();

    // back to reset values; receiver holds off while updates keep coming
    set_config(32'd25000, 32'd20, 32'd4000, 32'd300, 32'd60);
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (40) begin
      ms_clk += $urandom_range(0, 100);
      update_item(ms_clk);
    end
    tx_quiet = 1'b0;
    run_random(110);

    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(70);
    settle();

    if (fail_count == 0)
      $display("[dual_ultrasonic_echo_ranger] OK");
    else
      $display("[dual_ultrasonic_echo_ranger] ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/duer_pkg.sv
sv/duer_fold.sv
sv/dual_ultrasonic_echo_ranger.sv
sv/duer_checker.sv
verif/echo_range_checker.sv
verif/tb.sv
